// ===== sv/iaids_pkg.sv =====
// shared types and codes for the indexed array insert, delete and search unit
package iaids_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned POS_W  = 5;
    localparam int unsigned RES_W  = 5;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_DELETE = 2'd1;
    localparam logic [1:0] REQ_SEARCH = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BOUNDS  = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_MISSING = 2'd3;

    localparam logic [RES_W-1:0] NO_INDEX = '1;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DELETE,
        CELL_COMPARE,
        CELL_SCAN
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     at_pos;
        logic     past_pos;
    } t_cell_ctl;

endpackage

// ===== sv/iaids_cell.sv =====
// one array cell: holds an entry and a match flag, shifts with its neighbours
module iaids_cell
    import iaids_pkg::*;
(
    input  logic              i_clk,
    input  t_cell_ctl         i_ctl,
    input  logic [DATA_W-1:0] i_element,
    input  logic [DATA_W-1:0] i_key,
    input  logic [DATA_W-1:0] i_left_entry,
    input  logic [DATA_W-1:0] i_right_entry,
    input  logic              i_right_hit,
    output logic [DATA_W-1:0] o_entry,
    output logic              o_hit
);

    logic [DATA_W-1:0] r_entry;
    logic [DATA_W-1:0] n_entry;
    logic              r_hit;
    logic              n_hit;

    always_comb begin
        n_entry = r_entry;
        n_hit   = r_hit;
        case (i_ctl.op)
            CELL_INSERT: begin
                if (i_ctl.past_pos) begin
                    n_entry = i_left_entry;
                end else if (i_ctl.at_pos) begin
                    n_entry = i_element;
                end
            end
            CELL_DELETE: begin
                if (i_ctl.at_pos || i_ctl.past_pos) begin
                    n_entry = i_right_entry;
                end
            end
            CELL_COMPARE: n_hit = (r_entry == i_key);
            CELL_SCAN:    n_hit = i_right_hit;
            default: begin
                n_entry = r_entry;
                n_hit   = r_hit;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        r_hit   <= n_hit;
    end

    assign o_entry = r_entry;
    assign o_hit   = r_hit;

endmodule

// ===== sv/indexed_array_insert_delete_search_unit.sv =====
// top level: row of array cells with the request sequencer and result register
//
//  channel  | valid       | ready        | payload
//  request  | i_in_valid  | o_in_ready   | i_req_type i_position i_element i_key
//  result   | o_out_valid | i_out_ready  | o_status o_found_index o_entry_count
//
// insert, delete and bad requests finish in the cycle they are taken: one per cycle while the output is free
// a search compares every cell with the key, then scans until the lowest match reaches
// cell 0 or the scan reaches the count; match flags shift one cell a cycle to cell 0
// reset clears the count and the sequencer; entries stay undefined until written
// a new request is taken while one finished result waits on the output
module indexed_array_insert_delete_search_unit
    import iaids_pkg::*;
#(
    parameter int unsigned CAPACITY = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [1:0]              i_req_type,
    input  logic [POS_W-1:0]        i_position,
    input  logic signed [DATA_W-1:0] i_element,
    input  logic signed [DATA_W-1:0] i_key,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [1:0]              o_status,
    output logic signed [RES_W-1:0] o_found_index,
    output logic [RES_W-1:0]        o_entry_count
);

    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
    localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    t_state             r_state;
    t_state             n_state;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic [CNT_W-1:0]   r_scan;
    logic [CNT_W-1:0]   n_scan;
    logic               r_out_valid;
    logic               n_out_valid;
    logic [1:0]         r_out_status;
    logic [1:0]         n_out_status;
    logic [RES_W-1:0]   r_out_index;
    logic [RES_W-1:0]   n_out_index;
    logic [RES_W-1:0]   r_out_count;
    logic [RES_W-1:0]   n_out_count;
    logic [1:0]         r_res_status;
    logic [1:0]         n_res_status;
    logic [RES_W-1:0]   r_res_index;
    logic [RES_W-1:0]   n_res_index;
    logic [RES_W-1:0]   r_res_count;
    logic [RES_W-1:0]   n_res_count;

    t_cell_op           cell_op;
    logic               out_free;
    logic               res_done;
    logic [1:0]         res_status;
    logic [RES_W-1:0]   res_index;
    logic [CMP_W-1:0]   pos_ext;
    logic [CMP_W-1:0]   count_ext;
    logic [CMP_W-1:0]   scan_ext;
    logic [CMP_W-1:0]   n_count_ext;
    logic               in_xfer;

    logic [DATA_W-1:0]  w_entry [CAPACITY];
    logic               w_hit   [CAPACITY];

    assign in_xfer     = i_in_valid && o_in_ready;
    assign pos_ext     = CMP_W'(i_position);
    assign count_ext   = CMP_W'(r_count);
    assign scan_ext    = CMP_W'(r_scan);
    assign n_count_ext = CMP_W'(n_count);

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        localparam logic [CMP_W-1:0] CELL_IDX = CMP_W'(g);
        t_cell_ctl         ctl;
        logic [DATA_W-1:0] left_entry;
        logic [DATA_W-1:0] right_entry;
        logic              right_hit;

        assign ctl.op       = cell_op;
        assign ctl.at_pos   = (CELL_IDX == pos_ext);
        assign ctl.past_pos = (CELL_IDX > pos_ext);

        if (g == 0) begin : g_first
            assign left_entry = i_element;
        end else begin : g_inner_left
            assign left_entry = w_entry[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign right_entry = w_entry[g];
            assign right_hit   = 1'b0;
        end else begin : g_inner_right
            assign right_entry = w_entry[g+1];
            assign right_hit   = w_hit[g+1];
        end

        iaids_cell u_cell (
            .i_clk         (i_clk),
            .i_ctl         (ctl),
            .i_element     (i_element),
            .i_key         (i_key),
            .i_left_entry  (left_entry),
            .i_right_entry (right_entry),
            .i_right_hit   (right_hit),
            .o_entry       (w_entry[g]),
            .o_hit         (w_hit[g])
        );
    end

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_scan       = r_scan;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_index  = r_out_index;
        n_out_count  = r_out_count;
        n_res_status = r_res_status;
        n_res_index  = r_res_index;
        n_res_count  = r_res_count;
        cell_op      = CELL_HOLD;
        res_done     = 1'b0;
        res_status   = ST_BOUNDS;
        res_index    = NO_INDEX;
        out_free     = !r_out_valid || i_out_ready;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_req_type)
                        REQ_INSERT: begin
                            res_done = 1'b1;
                            if (pos_ext > count_ext) begin
                                res_status = ST_BOUNDS;
                            end else if (r_count >= CNT_W'(CAPACITY)) begin
                                res_status = ST_FULL;
                            end else begin
                                cell_op    = CELL_INSERT;
                                n_count    = r_count + CNT_W'(1);
                                res_status = ST_OK;
                            end
                        end
                        REQ_DELETE: begin
                            res_done = 1'b1;
                            if (pos_ext >= count_ext) begin
                                res_status = ST_BOUNDS;
                            end else begin
                                cell_op    = CELL_DELETE;
                                n_count    = r_count - CNT_W'(1);
                                res_status = ST_OK;
                            end
                        end
                        REQ_SEARCH: begin
                            cell_op = CELL_COMPARE;
                            n_scan  = '0;
                            n_state = S_SCAN;
                        end
                        default: begin
                            res_done   = 1'b1;
                            res_status = ST_BOUNDS;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                cell_op = CELL_SCAN;
                if (r_scan == r_count) begin
                    res_done   = 1'b1;
                    res_status = ST_MISSING;
                end else if (w_hit[0]) begin
                    res_done   = 1'b1;
                    res_status = ST_OK;
                    res_index  = scan_ext[RES_W-1:0];
                end else begin
                    n_scan = r_scan + CNT_W'(1);
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_index  = r_res_index;
                    n_out_count  = r_res_count;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (res_done) begin
            if (out_free) begin
                n_out_valid  = 1'b1;
                n_out_status = res_status;
                n_out_index  = res_index;
                n_out_count  = n_count_ext[RES_W-1:0];
                n_state      = S_IDLE;
            end else begin
                n_res_status = res_status;
                n_res_index  = res_index;
                n_res_count  = n_count_ext[RES_W-1:0];
                n_state      = S_DONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_scan       <= n_scan;
        r_out_status <= n_out_status;
        r_out_index  <= n_out_index;
        r_out_count  <= n_out_count;
        r_res_status <= n_res_status;
        r_res_index  <= n_res_index;
        r_res_count  <= n_res_count;
    end

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_found_index = r_out_index;
    assign o_entry_count = r_out_count;

`ifndef SYNTHESIS
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_scan <= r_count))
        else $error("scan ran past the stored entries");

    a_no_index_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != ST_OK)) |-> (o_found_index == NO_INDEX))
        else $error("index reported on a failed request");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> ((r_count == $past(r_count))
                  || (r_count == $past(r_count) + CNT_W'(1))
                  || (r_count + CNT_W'(1) == $past(r_count))))
        else $error("count moved by more than one entry");

    a_search_holds_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |=> $stable(r_count))
        else $error("count changed during a search");
`endif

endmodule

// ===== tb/indexed_array_insert_delete_search_unit_tb.sv =====
// self-checking testbench for the indexed array insert, delete and search unit
module indexed_array_insert_delete_search_unit_tb
    import iaids_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned DEPTH      = 16;
    localparam int unsigned RUN_ITEMS  = 1500;
    localparam int unsigned MAX_CYCLES = 400000;
    localparam int unsigned TAIL       = 60;
    localparam logic [1:0]  REQ_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]       status;
        logic [RES_W-1:0] found_index;
        logic [RES_W-1:0] entry_count;
    } t_array_result;

    class array_scoreboard;
        logic [DATA_W-1:0] cells [DEPTH];
        int unsigned       fill;
        t_array_result     awaited_q [$];
        int unsigned       mismatches;

        function new();
            fill       = 0;
            mismatches = 0;
            foreach (cells[i]) cells[i] = '0;
        endfunction

        function int unsigned pending();
            return awaited_q.size();
        endfunction

        function void note_request(logic [1:0] kind, logic [POS_W-1:0] pos,
                                   logic [DATA_W-1:0] elem, logic [DATA_W-1:0] key);
            t_array_result r;
            bit            hit;
            r.status      = ST_BOUNDS;
            r.found_index = NO_INDEX;
            hit           = 1'b0;
            case (kind)
                REQ_INSERT: begin
                    if (pos > fill) begin
                        r.status = ST_BOUNDS;
                    end else if (fill >= DEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        for (int i = fill; i > pos; i--) cells[i] = cells[i-1];
                        cells[pos] = elem;
                        fill++;
                        r.status = ST_OK;
                    end
                end
                REQ_DELETE: begin
                    if (pos >= fill) begin
                        r.status = ST_BOUNDS;
                    end else begin
                        for (int i = pos; i + 1 < fill; i++) cells[i] = cells[i+1];
                        fill--;
                        r.status = ST_OK;
                    end
                end
                REQ_SEARCH: begin
                    r.status = ST_MISSING;
                    for (int i = 0; i < fill; i++) begin
                        if (!hit && cells[i] == key) begin
                            hit           = 1'b1;
                            r.status      = ST_OK;
                            r.found_index = RES_W'(i);
                        end
                    end
                end
                default: begin
                    r.status = ST_BOUNDS;
                end
            endcase
            r.entry_count = RES_W'(fill);
            awaited_q.push_back(r);
        endfunction

        function void check_result(logic [1:0] st, logic [RES_W-1:0] idx,
                                   logic [RES_W-1:0] cnt);
            t_array_result r;
            if (awaited_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d index %0d count %0d",
                             st, idx, cnt);
                return;
            end
            r = awaited_q.pop_front();
            if (r.status !== st || r.found_index !== idx || r.entry_count !== cnt) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp st %0d idx %0d cnt %0d, got st %0d idx %0d cnt %0d",
                             r.status, r.found_index, r.entry_count, st, idx, cnt);
            end
        endfunction
    endclass

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_ready;
    logic [1:0]                i_req_type = REQ_INSERT;
    logic [POS_W-1:0]          i_position = '0;
    logic signed [DATA_W-1:0]  i_element = '0;
    logic signed [DATA_W-1:0]  i_key = '0;
    logic                      o_out_valid;
    logic                      i_out_ready = 1'b0;
    logic [1:0]                o_status;
    logic signed [RES_W-1:0]   o_found_index;
    logic [RES_W-1:0]          o_entry_count;

    array_scoreboard board = new();
    bit              idle_on = 1'b1;
    int unsigned     cycle_count = 0;

    indexed_array_insert_delete_search_unit #(
        .CAPACITY(DEPTH)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_req_type   (i_req_type),
        .i_position   (i_position),
        .i_element    (i_element),
        .i_key        (i_key),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_status     (o_status),
        .o_found_index(o_found_index),
        .o_entry_count(o_entry_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_out_ready <= !idle_on || ($urandom_range(99) >= 23);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            board.check_result(o_status, o_found_index, o_entry_count);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLES) begin
            $display("[indexed_array_insert_delete_search_unit] ERROR");
            $finish;
        end
    end

    task automatic send_request(input logic [1:0] kind, input logic [POS_W-1:0] pos,
                                input logic [DATA_W-1:0] elem,
                                input logic [DATA_W-1:0] key);
        while (idle_on && $urandom_range(99) < 23) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req_type <= kind;
        i_position <= pos;
        i_element  <= elem;
        i_key      <= key;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        board.note_request(kind, pos, elem, key);
    endtask

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(3))
            0: return DATA_W'($urandom_range(6)) - DATA_W'(3);
            1: begin
                case ($urandom_range(3))
                    0: return 32'h8000_0000;
                    1: return 32'h7fff_ffff;
                    2: return 32'hffff_ffff;
                    default: return 32'h0000_0000;
                endcase
            end
            default: return $urandom();
        endcase
    endfunction

    task automatic random_request(input bit grow);
        logic [1:0]        kind;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] key;
        int unsigned       roll;
        roll = $urandom_range(99);
        if (roll < 3)
            kind = REQ_UNUSED;
        else if (roll < 20)
            kind = REQ_SEARCH;
        else if (roll < 35)
            kind = grow ? REQ_DELETE : REQ_INSERT;
        else
            kind = grow ? REQ_INSERT : REQ_DELETE;
        if ($urandom_range(99) < 15)
            pos = POS_W'($urandom_range(31));
        else if (kind == REQ_DELETE && board.fill > 0)
            pos = POS_W'($urandom_range(board.fill - 1));
        else
            pos = POS_W'($urandom_range(board.fill));
        if (board.fill > 0 && $urandom_range(99) < 60)
            key = board.cells[$urandom_range(board.fill - 1)];
        else
            key = pick_value();
        send_request(kind, pos, pick_value(), key);
    endtask

    initial begin
        bit grow;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty array corners
        send_request(REQ_SEARCH, 5'd0, 32'h0, 32'h0);
        send_request(REQ_DELETE, 5'd0, 32'h0, 32'h0);
        send_request(REQ_INSERT, 5'd1, 32'h1234_5678, 32'h0);
        send_request(REQ_UNUSED, 5'd0, 32'h0, 32'h0);
        // inserts at front, end and middle with extreme values
        send_request(REQ_INSERT, 5'd0, 32'h8000_0000, 32'h0);
        send_request(REQ_INSERT, 5'd1, 32'h7fff_ffff, 32'h0);
        send_request(REQ_INSERT, 5'd0, 32'hffff_ffff, 32'h0);
        send_request(REQ_INSERT, 5'd1, 32'h0000_0000, 32'hffff_ffff);
        send_request(REQ_SEARCH, 5'd31, 32'h0, 32'h7fff_ffff);
        // duplicate value, lowest index wins
        send_request(REQ_INSERT, 5'd4, 32'h8000_0000, 32'h0);
        send_request(REQ_SEARCH, 5'd0, 32'hffff_ffff, 32'h8000_0000);
        // out of range positions
        send_request(REQ_INSERT, 5'd31, 32'h5555_5555, 32'h0);
        send_request(REQ_DELETE, 5'd31, 32'h0, 32'h0);
        send_request(REQ_DELETE, 5'd5, 32'h0, 32'h0);
        // delete last, first, middle
        send_request(REQ_DELETE, 5'd4, 32'h0, 32'h0);
        send_request(REQ_DELETE, 5'd0, 32'h0, 32'h0);
        send_request(REQ_DELETE, 5'd1, 32'h0, 32'h0);
        send_request(REQ_SEARCH, 5'd0, 32'h0, 32'haaaa_aaaa);
        // fill to capacity, then full and bounds ordering
        while (board.fill < DEPTH)
            send_request(REQ_INSERT, POS_W'(board.fill), $urandom(), 32'h0);
        send_request(REQ_INSERT, 5'd16, 32'h1, 32'h0);
        send_request(REQ_INSERT, 5'd17, 32'h1, 32'h0);
        send_request(REQ_DELETE, 5'd16, 32'h0, 32'h0);
        send_request(REQ_SEARCH, 5'd0, 32'h0, board.cells[DEPTH-1]);
        send_request(REQ_SEARCH, 5'd0, 32'h0, 32'h1357_9bdf);

        grow = 1'b0;
        for (int n = 0; n < RUN_ITEMS; n++) begin
            if (board.fill == DEPTH)
                grow = 1'b0;
            else if (board.fill == 0)
                grow = 1'b1;
            else if ($urandom_range(59) == 0)
                grow = !grow;
            idle_on = !(n >= 600 && n < 800);
            if (n == 1000) begin
                // hold off until the unit has returned every result
                i_in_valid <= 1'b0;
                @(posedge i_clk);
                while (board.pending() > 0) @(posedge i_clk);
            end
            random_request(grow);
        end

        i_in_valid <= 1'b0;
        while (board.pending() > 0) @(posedge i_clk);
        repeat (TAIL) @(posedge i_clk);
        if (board.pending() > 0) begin
            board.mismatches++;
            $display("results missing: %0d", board.pending());
        end
        if (board.mismatches == 0) begin
            $display("[indexed_array_insert_delete_search_unit] OK");
        end else begin
            $display("[indexed_array_insert_delete_search_unit] ERROR");
        end
        $finish;
    end

endmodule

// ===== indexed_array_insert_delete_search_unit.f =====
sv/iaids_pkg.sv
sv/iaids_cell.sv
sv/indexed_array_insert_delete_search_unit.sv
tb/indexed_array_insert_delete_search_unit_tb.sv
